FILE: rtl/core/rpi_pkg.sv
`default_nettype none

package rpi_pkg;

    localparam int POS_W     = 32;
    localparam int DT_W      = 20;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W = 120;
    localparam int NUM_W     = 64;
    localparam int ROOT_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PROG = 3'd6;

    localparam logic [1:0] PH_RISE   = 2'd0;
    localparam logic [1:0] PH_FALL   = 2'd1;
    localparam logic [1:0] PH_CRUISE = 2'd2;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_REVERT = 1'b1;

    typedef enum logic {
        ITER_SQRT,
        ITER_DIV
    } t_iter_mode;

    typedef struct packed {
        logic       start;
        t_iter_mode mode;
    } t_iter_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REVERT,
        ST_DRV,
        ST_DRV_WAIT,
        ST_DIFF,
        ST_SQ,
        ST_SQRT,
        ST_SQRT_WAIT,
        ST_PICK,
        ST_DIV_WAIT,
        ST_LERP,
        ST_INC,
        ST_ACC,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/rpi_iter.sv
`default_nettype none

module rpi_iter #(
    parameter int FRAC_BITS = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  rpi_pkg::t_iter_ctl         i_ctl,
    input  wire  [rpi_pkg::NUM_W-1:0]  i_num,
    input  wire  [rpi_pkg::ROOT_W-1:0] i_den,
    output logic                       o_done,
    output logic [rpi_pkg::ROOT_W-1:0] o_root
);
    import rpi_pkg::*;

    localparam int RW = 35;

    logic             r_busy;
    logic             r_done;
    logic [5:0]       r_cnt;
    t_iter_mode       r_mode;
    logic [NUM_W-1:0] r_rad;
    logic [33:0]      r_rem;
    logic [31:0]      r_q;
    logic [31:0]      r_den;

    logic [RW-1:0]    w_sh;
    logic [RW-1:0]    w_trial;
    logic [RW:0]      w_diff;
    logic             w_ge;

    // one shared subtract: sqrt remainder step or restoring divide step
    always_comb begin
        if (r_mode == ITER_SQRT) begin
            w_sh    = {r_rem[32:0], r_rad[NUM_W-1:NUM_W-2]};
            w_trial = {1'b0, r_q, 2'b01};
        end else begin
            w_sh    = {r_rem, 1'b0};
            w_trial = {3'b000, r_den};
        end
        w_diff = {1'b0, w_sh} - {1'b0, w_trial};
        w_ge   = ~w_diff[RW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_ctl.mode == ITER_SQRT) ? 6'd32 : 6'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mode <= i_ctl.mode;
            r_rad  <= i_num;
            r_rem  <= (i_ctl.mode == ITER_SQRT) ? 34'd0 : {2'b00, i_num[31:0]};
            r_q    <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rad <= {r_rad[NUM_W-3:0], 2'b00};
            r_rem <= w_ge ? w_diff[33:0] : w_sh[33:0];
            r_q   <= {r_q[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_q;

endmodule

`default_nettype wire

FILE: rtl/core/ramped_progress_integrator_core.sv
`default_nettype none

// Ramped progress integrator. Each update word (tuser op = 0) measures the
// distance of the given position from the start point with a 32-step square
// root, picks a speed multiplier on a trapezoidal profile over that distance
// (an F-step divide for the ramp fraction, F = MULT_FRAC_BITS) and adds
// delta_time * rate_gain * multiplier to a saturating progress accumulator.
// A revert word (op = 1) restores the progress held before the last update.
// Both iterative steps share one subtractor in rpi_iter; products go through
// one registered 33x33 multiplier. In cruise the divide and blend are skipped,
// past the end of the ramp only the divide. The first update after a write to
// a geometry register first rederives ramp length and peak, with an extra
// divide when the ramp is shortened to half the total. One word is in work at
// a time; s_axis_tready is high only while the core is idle.

module ramped_progress_integrator_core #(
    parameter int PROGRESS_WIDTH = 48,
    parameter int MULT_FRAC_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x, pos_y, pos_z, delta_time, zero pad
    input  wire  [rpi_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // op
    input  wire  [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // progress, speed_mult, zero pad
    output logic [((PROGRESS_WIDTH+MULT_FRAC_BITS+1+7)/8)*8-1:0] m_axis_tdata,
    // phase
    output logic [1:0]  m_axis_tuser,
    input  wire         i_cfg_we,
    input  wire  [rpi_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [rpi_pkg::CFG_W-1:0]     i_cfg_data
);
    import rpi_pkg::*;

    localparam int F      = MULT_FRAC_BITS;
    localparam int PW     = PROGRESS_WIDTH;
    localparam int MW     = F + 1;
    localparam int OUT_W  = ((PW + MW + 7) / 8) * 8;
    localparam int TOT_W  = 52 + MW;
    localparam int INC_W  = TOT_W - 16 - F;
    localparam logic [MW-1:0] ONE = MW'(1) << F;
    localparam logic [MW-1:0] LOW = MW'(((1 << F) + 500) / 1000);
    localparam logic [65:0] PMAX66 = (66'd1 << (PW - 1)) - 66'd1;
    localparam logic signed [65:0] SMAX = $signed(PMAX66);
    localparam logic signed [65:0] SMIN = -SMAX - 66'sd1;

    t_state r_state, n_state;

    logic [31:0]    r_start_x, r_start_y, r_start_z, r_total, r_ramp, r_gain;
    logic           r_dirty;
    logic [31:0]    r_rl;
    logic [MW-1:0]  r_peak;
    logic [PW-1:0]  r_acc, r_saved;

    logic [31:0]    r_pos_x, r_pos_y, r_pos_z;
    logic [DT_W-1:0] r_dt;
    logic [32:0]    r_da, r_db, r_dc;
    logic [65:0]    r_prod, r_sum;
    logic [31:0]    r_dist;
    logic [MW-1:0]  r_t, r_la, r_lb, r_mult;
    logic [1:0]     r_phase;
    logic [25:0]    r_hi;
    logic [INC_W-1:0] r_inc;
    logic [1:0]     r_step;

    logic           r_m_valid;
    logic [PW-1:0]  r_m_prog;
    logic [MW-1:0]  r_m_mult;
    logic [1:0]     r_m_phase;

    logic           w_accept;
    logic           w_out_load;
    logic [32:0]    w_ma, w_mb;
    t_iter_ctl      w_ctl;
    logic [NUM_W-1:0] w_num;
    logic [31:0]    w_den;
    logic           w_done;
    logic [31:0]    w_root;

    logic [31:0]    w_edge, w_fall_x;
    logic           w_in_rise, w_in_fall, w_fall_sat, w_shrink;
    logic signed [32:0] w_dx, w_dy, w_dz;
    logic [TOT_W-1:0] w_tot;
    logic [65:0]    w_room;
    logic signed [65:0] w_init;
    logic [65:0]    w_lsum;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_load = (r_state == ST_OUT) && (!r_m_valid || m_axis_tready);

    assign w_edge     = r_total - r_rl;
    assign w_fall_x   = r_dist - w_edge;
    assign w_in_rise  = r_dist < r_rl;
    assign w_in_fall  = r_dist > w_edge;
    assign w_fall_sat = w_fall_x >= r_rl;
    assign w_shrink   = {r_ramp, 1'b0} > {1'b0, r_total};

    assign w_dx = $signed({r_pos_x[31], r_pos_x}) - $signed({r_start_x[31], r_start_x});
    assign w_dy = $signed({r_pos_y[31], r_pos_y}) - $signed({r_start_y[31], r_start_y});
    assign w_dz = $signed({r_pos_z[31], r_pos_z}) - $signed({r_start_z[31], r_start_z});

    assign w_tot  = {r_prod[25+MW:0], 26'd0} + TOT_W'(r_sum[25+MW:0]);
    assign w_room = PMAX66 - {{(66-PW){r_acc[PW-1]}}, r_acc};
    assign w_init = $signed({{(66-CFG_W){i_cfg_data[CFG_W-1]}}, i_cfg_data});
    assign w_lsum = r_sum + r_prod;

    rpi_iter #(
        .FRAC_BITS (F)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_root  (w_root)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser[0] == OP_REVERT) n_state = ST_REVERT;
                    else if (r_dirty)                 n_state = ST_DRV;
                    else                              n_state = ST_DIFF;
                end
            end
            ST_REVERT:   n_state = ST_OUT;
            ST_DRV:      n_state = w_shrink ? ST_DRV_WAIT : ST_DIFF;
            ST_DRV_WAIT: if (w_done) n_state = ST_DIFF;
            ST_DIFF:     n_state = ST_SQ;
            ST_SQ:       if (r_step == 2'd3) n_state = ST_SQRT;
            ST_SQRT:     n_state = (r_sum[65:64] != 2'b00) ? ST_PICK : ST_SQRT_WAIT;
            ST_SQRT_WAIT: if (w_done) n_state = ST_PICK;
            ST_PICK: begin
                if (r_rl == 32'd0)                  n_state = ST_INC;
                else if (w_in_rise)                 n_state = ST_DIV_WAIT;
                else if (w_in_fall && !w_fall_sat)  n_state = ST_DIV_WAIT;
                else if (w_in_fall)                 n_state = ST_LERP;
                else                                n_state = ST_INC;
            end
            ST_DIV_WAIT: if (w_done) n_state = ST_LERP;
            ST_LERP:     if (r_step == 2'd2) n_state = ST_INC;
            ST_INC:      if (r_step == 2'd3) n_state = ST_ACC;
            ST_ACC:      n_state = ST_OUT;
            ST_OUT:      if (w_out_load) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // control outputs: input ready, multiplier operands and iterative unit requests
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        w_ma      = '0;
        w_mb      = '0;
        w_ctl     = '{start: 1'b0, mode: ITER_DIV};
        w_num     = '0;
        w_den     = r_rl;
        case (r_state)
            ST_DRV: begin
                w_ctl = '{start: w_shrink, mode: ITER_DIV};
                w_num = NUM_W'(r_total >> 1);
                w_den = r_ramp;
            end
            ST_SQ: begin
                case (r_step)
                    2'd0:    begin w_ma = r_da; w_mb = r_da; end
                    2'd1:    begin w_ma = r_db; w_mb = r_db; end
                    2'd2:    begin w_ma = r_dc; w_mb = r_dc; end
                    default: begin w_ma = '0;   w_mb = '0;   end
                endcase
            end
            ST_SQRT: begin
                w_ctl = '{start: (r_sum[65:64] == 2'b00), mode: ITER_SQRT};
                w_num = r_sum[NUM_W-1:0];
            end
            ST_PICK: begin
                if (r_rl != 32'd0) begin
                    if (w_in_rise) begin
                        w_ctl = '{start: 1'b1, mode: ITER_DIV};
                        w_num = NUM_W'(r_dist);
                    end else if (w_in_fall && !w_fall_sat) begin
                        w_ctl = '{start: 1'b1, mode: ITER_DIV};
                        w_num = NUM_W'(w_fall_x);
                    end
                end
            end
            ST_LERP: begin
                case (r_step)
                    2'd0:    begin w_ma = 33'(r_la); w_mb = 33'(ONE - r_t); end
                    2'd1:    begin w_ma = 33'(r_lb); w_mb = 33'(r_t);       end
                    default: begin w_ma = '0;        w_mb = '0;             end
                endcase
            end
            ST_INC: begin
                case (r_step)
                    2'd0:    begin w_ma = 33'(r_dt);         w_mb = 33'(r_gain); end
                    2'd1:    begin w_ma = 33'(r_prod[25:0]); w_mb = 33'(r_mult); end
                    2'd2:    begin w_ma = 33'(r_hi);         w_mb = 33'(r_mult); end
                    default: begin w_ma = '0;                w_mb = '0;          end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_start_x <= '0;
            r_start_y <= '0;
            r_start_z <= '0;
            r_total   <= '0;
            r_ramp    <= '0;
            r_gain    <= 32'd65536;
            r_dirty   <= 1'b0;
            r_rl      <= '0;
            r_peak    <= ONE;
            r_acc     <= '0;
            r_saved   <= '0;
            r_step    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_X: r_start_x <= i_cfg_data[31:0];
                    CFG_START_Y: r_start_y <= i_cfg_data[31:0];
                    CFG_START_Z: r_start_z <= i_cfg_data[31:0];
                    CFG_TOTAL:   r_total   <= i_cfg_data[31:0];
                    CFG_RAMP:    r_ramp    <= i_cfg_data[31:0];
                    CFG_GAIN:    r_gain    <= i_cfg_data[31:0];
                    CFG_INIT_PROG: begin
                        if (w_init > SMAX) begin
                            r_acc   <= SMAX[PW-1:0];
                            r_saved <= SMAX[PW-1:0];
                        end else if (w_init < SMIN) begin
                            r_acc   <= SMIN[PW-1:0];
                            r_saved <= SMIN[PW-1:0];
                        end else begin
                            r_acc   <= w_init[PW-1:0];
                            r_saved <= w_init[PW-1:0];
                        end
                    end
                    default: ;
                endcase
                if (i_cfg_idx inside {[CFG_START_X:CFG_RAMP]}) r_dirty <= 1'b1;
            end

            if ((r_state == ST_SQ) || (r_state == ST_LERP) || (r_state == ST_INC)) begin
                r_step <= (n_state == r_state) ? r_step + 2'd1 : 2'd0;
            end

            case (r_state)
                ST_REVERT: r_acc <= r_saved;
                ST_DRV: begin
                    r_dirty <= 1'b0;
                    if (w_shrink) begin
                        r_rl <= r_total >> 1;
                    end else begin
                        r_rl   <= r_ramp;
                        r_peak <= ONE;
                    end
                end
                ST_DRV_WAIT: if (w_done) r_peak <= MW'(w_root[F-1:0]);
                ST_ACC: begin
                    r_saved <= r_acc;
                    if (66'(r_inc) > w_room) r_acc <= PMAX66[PW-1:0];
                    else                     r_acc <= r_acc + PW'(r_inc);
                end
                default: ;
            endcase

            if (w_out_load)                       r_m_valid <= 1'b1;
            else if (m_axis_tready)               r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (w_accept) begin
            r_pos_x <= s_axis_tdata[31:0];
            r_pos_y <= s_axis_tdata[63:32];
            r_pos_z <= s_axis_tdata[95:64];
            r_dt    <= s_axis_tdata[115:96];
        end
        case (r_state)
            ST_REVERT: begin
                r_phase <= PH_CRUISE;
                r_mult  <= '0;
            end
            ST_DIFF: begin
                r_da <= w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
                r_db <= w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
                r_dc <= w_dz[32] ? 33'(-w_dz) : 33'(w_dz);
            end
            ST_SQ: begin
                if (r_step == 2'd1)      r_sum <= r_prod;
                else if (r_step != 2'd0) r_sum <= r_sum + r_prod;
            end
            ST_SQRT: if (r_sum[65:64] != 2'b00) r_dist <= '1;
            ST_SQRT_WAIT: if (w_done) r_dist <= w_root;
            ST_PICK: begin
                r_phase <= PH_CRUISE;
                r_mult  <= ONE;
                r_t     <= ONE;
                if (r_rl != 32'd0) begin
                    if (w_in_rise) begin
                        r_phase <= PH_RISE;
                        r_la    <= LOW;
                        r_lb    <= r_peak;
                    end else if (w_in_fall) begin
                        r_phase <= PH_FALL;
                        r_la    <= r_peak;
                        r_lb    <= LOW;
                    end
                end
            end
            ST_DIV_WAIT: if (w_done) r_t <= MW'(w_root[F-1:0]);
            ST_LERP: begin
                if (r_step == 2'd1) r_sum <= r_prod;
                if (r_step == 2'd2) r_mult <= w_lsum[F+MW-1:F];
            end
            ST_INC: begin
                if (r_step == 2'd1) r_hi <= r_prod[51:26];
                if (r_step == 2'd2) r_sum <= r_prod;
                if (r_step == 2'd3) r_inc <= w_tot[TOT_W-1:16+F];
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_m_prog  <= r_acc;
            r_m_mult  <= r_mult;
            r_m_phase <= r_phase;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_W'({r_m_mult, r_m_prog});
    assign m_axis_tuser  = r_m_phase;

endmodule

`default_nettype wire

FILE: rtl/core/rpi_checker.sv
`default_nettype none

module rpi_checker #(
    parameter int PROGRESS_WIDTH = 48,
    parameter int MULT_FRAC_BITS = 16
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        i_s_tready,
    input wire        i_m_tvalid,
    input wire        i_m_tready,
    input wire [((PROGRESS_WIDTH+MULT_FRAC_BITS+1+7)/8)*8-1:0] i_m_tdata,
    input wire [1:0]  i_m_tuser
);
    localparam int PW = PROGRESS_WIDTH;
    localparam int F  = MULT_FRAC_BITS;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("output word dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input taken while a word is in work");

    a_mult_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[PW+F:PW] <= ONE) && (i_m_tuser != 2'd3))
        else $error("speed multiplier or phase out of range");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_tvalid) |-> !$past(i_s_tready))
        else $error("result appeared without work in progress");

endmodule

bind ramped_progress_integrator_core rpi_checker #(
    .PROGRESS_WIDTH (PROGRESS_WIDTH),
    .MULT_FRAC_BITS (MULT_FRAC_BITS)
) u_rpi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rpi_pkg::*;

    localparam int PW = 48;
    localparam int FB = 16;
    localparam int OUT_W = ((PW + FB + 1 + 7) / 8) * 8;
    localparam logic [63:0] M_ONE = 64'd1 << FB;
    localparam logic [63:0] M_LOW = (M_ONE + 64'd500) / 64'd1000;
    localparam longint P_MAX = (64'sd1 <<< (PW - 1)) - 1;
    localparam longint P_MIN = -P_MAX - 1;

    typedef struct packed {
        logic        op;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [19:0] dt;
    } t_word;

    typedef struct packed {
        logic [PW-1:0] prog;
        logic [1:0]    ph;
        logic [FB:0]   mult;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    ramped_progress_integrator_core #(.PROGRESS_WIDTH(PW), .MULT_FRAC_BITS(FB)) i_dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // profile state
    logic [31:0] sx, sy, sz, tot, rmp, gain;
    logic [63:0] ramp_len, peak;
    longint acc, saved;

    t_word pending[$];
    t_res  expected_res[$];
    int errors = 0;
    int n_sent = 0;
    bit hold_off = 0;
    bit stim_done = 0;

    function automatic void rederive();
        if ({32'd0, rmp} * 2 > {32'd0, tot}) begin
            ramp_len = {32'd0, tot} >> 1;
            peak = (ramp_len << FB) / {32'd0, rmp};
        end else begin
            ramp_len = {32'd0, rmp};
            peak = M_ONE;
        end
    endfunction

    function automatic logic [63:0] mag(logic [31:0] p, logic [31:0] s);
        longint d;
        d = longint'($signed(p)) - longint'($signed(s));
        return d < 0 ? -d : d;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] t);
        return (a * (M_ONE - t) + b * t) >> FB;
    endfunction

    function automatic t_res advance_progress(t_word w);
        t_res r;
        logic [63:0] a, b, c, s1, s2, s3, d, m, t, edge_pt, hi, lo, inc, room;
        logic [1:0] ph;
        bit ovf;
        m = M_ONE;
        ph = PH_CRUISE;
        if (w.op == OP_REVERT) begin
            acc = saved;
            m = 0;
        end else begin
            a = mag(w.px, sx);
            b = mag(w.py, sy);
            c = mag(w.pz, sz);
            s1 = a * a;
            s2 = s1 + b * b;
            ovf = s2 < s1;
            s3 = s2 + c * c;
            if (s3 < s2) ovf = 1;
            d = ovf ? 64'hFFFF_FFFF : root64(s3);
            if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
            if (ramp_len != 0) begin
                edge_pt = {32'd0, tot} - ramp_len;
                if (d < ramp_len) begin
                    t = (d << FB) / ramp_len;
                    m = blend(M_LOW, peak, t);
                    ph = PH_RISE;
                end else if (d > edge_pt) begin
                    t = ((d - edge_pt) << FB) / ramp_len;
                    if (t > M_ONE) t = M_ONE;
                    m = blend(peak, M_LOW, t);
                    ph = PH_FALL;
                end
            end
            t = {44'd0, w.dt} * {32'd0, gain};
            hi = t >> 16;
            lo = t & 64'hFFFF;
            inc = (hi * m + ((lo * m) >> 16)) >> FB;
            room = P_MAX - acc;
            saved = acc;
            if (inc > room) acc = P_MAX;
            else acc = acc + longint'(inc);
        end
        r.prog = acc[PW-1:0];
        r.ph = ph;
        r.mult = m[FB:0];
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        longint v;
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_START_X: sx = val[31:0];
            CFG_START_Y: sy = val[31:0];
            CFG_START_Z: sz = val[31:0];
            CFG_TOTAL: tot = val[31:0];
            CFG_RAMP: rmp = val[31:0];
            CFG_GAIN: gain = val[31:0];
            CFG_INIT_PROG: begin
                v = longint'($signed(val));
                if (v > P_MAX) v = P_MAX;
                if (v < P_MIN) v = P_MIN;
                acc = v;
                saved = v;
            end
            default: ;
        endcase
        rederive();
    endtask

    task automatic drain();
        wait (pending.size() == 0 && expected_res.size() == 0);
        repeat (120) @(negedge i_clk);
    endtask

    function automatic t_word rand_word(logic [31:0] span);
        t_word w;
        w.op = ($urandom_range(0, 9) == 0) ? OP_REVERT : OP_UPDATE;
        if ($urandom_range(0, 7) == 0) begin
            w.px = $urandom;
            w.py = $urandom;
            w.pz = $urandom;
        end else begin
            w.px = sx + $urandom_range(0, span) - span / 2;
            w.py = sy + $urandom_range(0, span / 4) - span / 8;
            w.pz = sz + $urandom_range(0, span / 4) - span / 8;
        end
        w.dt = ($urandom_range(0, 5) == 0) ? 20'hFFFFF : 20'($urandom);
        return w;
    endfunction

    // profile settings: start x/y/z, total, ramp, gain, initial progress
    task automatic set_profile(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] t, logic [31:0] r, logic [31:0] g,
                               logic [47:0] ip);
        write_reg(CFG_START_X, {16'd0, x});
        write_reg(CFG_START_Y, {16'd0, y});
        write_reg(CFG_START_Z, {16'd0, z});
        write_reg(CFG_TOTAL, {16'd0, t});
        write_reg(CFG_RAMP, {16'd0, r});
        write_reg(CFG_GAIN, {16'd0, g});
        write_reg(CFG_INIT_PROG, ip);
    endtask

    task automatic push(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                        logic [19:0] dt);
        t_word w;
        w = '{op: op, px: x, py: y, pz: z, dt: dt};
        pending.push_back(w);
    endtask

    initial begin
        sx = 0; sy = 0; sz = 0; tot = 0; rmp = 0; gain = 32'd65536;
        acc = 0; saved = 0;
        rederive();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // zero ramp length: cruise
        push(OP_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 20'hFFFFF);
        push(OP_REVERT, 0, 0, 0, 0);
        drain();
        set_profile(0, 0, 0, 32'd100000, 32'd20000, 32'hFFFF_FFFF, 48'h7FFF_FFFF_0000);
        push(OP_UPDATE, 0, 0, 0, 20'h10000);
        push(OP_UPDATE, 32'd10000, 0, 0, 20'hFFFFF);
        push(OP_UPDATE, 32'd50000, 0, 0, 20'h10000);
        push(OP_UPDATE, 32'd90000, 0, 0, 20'h10000);
        push(OP_UPDATE, 32'd200000, 0, 0, 20'h10000);
        push(OP_UPDATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20'h0);
        push(OP_REVERT, 0, 0, 0, 0);
        push(OP_REVERT, 0, 0, 0, 0);
        drain();
        // ramp longer than half the total: peak shrinks; negative start
        set_profile(32'hFFFF_0000, 32'd300, 32'h8000_0000, 32'd40000, 32'd30000,
                    32'd65536, 48'h8000_0000_0000);
        push(OP_UPDATE, 32'hFFFF_0000, 32'd300, 32'h8000_0000, 20'hFFFFF);
        push(OP_UPDATE, 32'hFFFF_4000, 32'd300, 32'h8000_0000, 20'hFFFFF);
        push(OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'hFFFFF);
        push(OP_REVERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF);
        drain();
        write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
        set_profile(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65536, 0);
        push(OP_UPDATE, 32'h1000, 0, 0, 20'h10000);
        push(OP_UPDATE, 32'h7FFF_FFFF, 0, 0, 20'h10000);
        drain();
        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            logic [31:0] t;
            t = (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(1000, 1 << 20);
            set_profile($urandom, $urandom, $urandom, t,
                        (ph == 0) ? 32'd0 : $urandom_range(0, t),
                        (ph == 4) ? 32'd0 : $urandom_range(0, 1 << 20),
                        {16'($urandom_range(0, 1 << 15)), 32'($urandom)});
            if (ph == 2) hold_off = 1;
            for (int i = 0; i < 250; i++) begin
                pending.push_back(rand_word(t * 2 + 16));
                if (i == 120) wait (pending.size() == 0 && expected_res.size() == 0);
            end
            drain();
        end
        stim_done = 1;
    end

    // handshakes seen at the rising edge
    bit s_taken = 1'b0;
    bit m_taken = 1'b0;
    always @(posedge i_clk) begin
        s_taken <= s_axis_tvalid && s_axis_tready;
        m_taken <= m_axis_tvalid && m_axis_tready;
    end

    // driver
    int src_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_taken) begin
                expected_res.push_back(advance_progress(pending.pop_front()));
                src_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
                n_sent++;
            end
            if (s_axis_tvalid && !s_taken) begin
            end else if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= IN_DATA_W'({pending[0].dt, pending[0].pz, pending[0].py,
                                            pending[0].px});
                s_axis_tuser <= pending[0].op;
            end else s_axis_tvalid <= 1'b0;
        end
    end

    // receiver stalls
    int snk_gap = 0;
    int long_hold = 0;
    bit hold_used = 0;
    always @(negedge i_clk) begin
        if (hold_off && !hold_used && long_hold == 0) begin
            long_hold = 400;
            hold_used = 1;
        end
        if (long_hold > 0) begin
            long_hold--;
            m_axis_tready <= 1'b0;
        end else if (m_taken) begin
            snk_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            m_axis_tready <= snk_gap == 0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            m_axis_tready <= snk_gap == 0;
        end else m_axis_tready <= 1'b1;
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        logic [PW-1:0] got_p;
        logic [FB:0] got_m;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_p = m_axis_tdata[PW-1:0];
            got_m = m_axis_tdata[PW+FB:PW];
            if (expected_res.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", m_axis_tdata);
            end else begin
                e = expected_res.pop_front();
                if (got_p !== e.prog || m_axis_tuser !== e.ph || got_m !== e.mult) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp prog %h ph %0d mult %h, got %h %0d %h",
                                 e.prog, e.ph, e.mult, got_p, m_axis_tuser, got_m);
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_res.size() == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench failed");
        $finish;
    end

endmodule
